[src/ngt_pkg.sv]
// Package: shared constants, types and helpers for the neural gas trainer.
`default_nettype none
package ngt_pkg;
  localparam int NUM_CENTROIDS = 16;
  localparam int DIMS = 2;
  localparam int NUM_EPOCHS = 10;
  localparam int MAXD = 4;
  localparam int SLOT_W = $clog2(NUM_CENTROIDS);
  localparam int CNT_W = $clog2(NUM_CENTROIDS + 1);
  localparam int EP_W = (NUM_EPOCHS > 1) ? $clog2(NUM_EPOCHS) : 1;
  localparam int WT_DEPTH = NUM_EPOCHS * NUM_CENTROIDS;
  localparam int WT_AW = $clog2(WT_DEPTH);
  localparam int DIST_W = 35;
  localparam int CRD_W = 16;

  typedef enum logic [1:0] {
    OP_TRAIN = 2'd0,
    OP_LOAD_WEIGHT = 2'd1,
    OP_READ = 2'd2,
    OP_WRITE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_RANK,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic [DIST_W-1:0] dist_t;

  // Squared difference of one coordinate, summed over the active dims.
  function automatic dist_t sq_dist(input crd_t s [MAXD], input crd_t c [MAXD]);
    logic signed [CRD_W:0] df;
    logic [2*CRD_W+1:0] acc;
    acc = '0;
    for (int k = 0; k < DIMS; k++) begin
      df = 17'(s[k]) - 17'(c[k]);
      acc = acc + 34'(df * df);
    end
    return dist_t'(acc);
  endfunction

  // Move one coordinate toward the sample by weight w, round half up, saturate.
  function automatic crd_t move_crd(input crd_t s, input crd_t c, input logic [15:0] w);
    logic signed [CRD_W:0] df;
    logic signed [34:0] prod;
    logic signed [18:0] delta;
    logic signed [19:0] sum;
    df = 17'(s) - 17'(c);
    prod = $signed({1'b0, w}) * df;
    prod = prod + 35'sd32768;
    delta = 19'(prod >>> 16);
    sum = 20'(c) + 20'(delta);
    if (sum > 20'sd32767) return crd_t'(16'sh7fff);
    if (sum < -20'sd32768) return crd_t'(16'sh8000);
    return crd_t'(sum);
  endfunction
endpackage
`default_nettype wire

[src/ngt_ram.sv]
// Generic single-port-write RAM with registered read.
`default_nettype none
module ngt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/ngt_lane.sv]
// One centroid lane: distance, rank count and update for its own centroid.
`default_nettype none
module ngt_lane (
  input  wire logic                clk,
  input  wire logic                ld_en,
  input  wire ngt_pkg::crd_t       ld_crd [ngt_pkg::MAXD],
  input  wire logic                dist_en,
  input  wire ngt_pkg::crd_t       smp [ngt_pkg::MAXD],
  input  wire logic                rank_clr,
  input  wire logic                rank_en,
  input  wire ngt_pkg::dist_t      peer_dist,
  input  wire logic                peer_lower,
  input  wire logic                upd_en,
  input  wire logic [15:0]         upd_w,
  output ngt_pkg::crd_t            crd [ngt_pkg::MAXD],
  output ngt_pkg::dist_t           sqd,
  output logic [ngt_pkg::SLOT_W-1:0] rank
);
  import ngt_pkg::*;
  crd_t crd_r [MAXD];
  dist_t dist_r;
  logic [SLOT_W-1:0] rank_r;

  always_ff @(posedge clk) begin
    if (ld_en) crd_r <= ld_crd;
    else if (upd_en) begin
      for (int k = 0; k < MAXD; k++)
        crd_r[k] <= (k < DIMS) ? move_crd(smp[k], crd_r[k], upd_w) : crd_r[k];
    end
    if (dist_en) dist_r <= sq_dist(smp, crd_r);
    // count peers that sort ahead of this lane
    if (rank_clr) rank_r <= '0;
    else if (rank_en && (peer_dist < dist_r || (peer_dist == dist_r && peer_lower)))
      rank_r <= rank_r + 1'b1;
  end
  assign crd = crd_r;
  assign sqd = dist_r;
  assign rank = rank_r;
endmodule
`default_nettype wire

[src/neural_gas_trainer_top.sv]
// One request at a time: the next is taken the cycle after the result leaves,
// so an output stall also holds off the next request.
// Ranking walks one peer per cycle, so the rank sweep sets the rate.
// Reset (synchronous, rst_n low) clears control state only; centroids and weights
// are undefined until written.
`default_nettype none
module neural_gas_trainer_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_opcode,
  input  wire logic [3:0]                 in_epoch,
  input  wire logic [3:0]                 in_slot,
  input  wire logic [15:0]                in_weight,
  input  wire logic signed [15:0]         in_coord_0,
  input  wire logic signed [15:0]         in_coord_1,
  input  wire logic signed [15:0]         in_coord_2,
  input  wire logic signed [15:0]         in_coord_3,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [3:0]                      out_winner_slot,
  output logic [34:0]                     out_winner_sq_distance,
  output logic signed [15:0]              out_read_coord_0,
  output logic signed [15:0]              out_read_coord_1,
  output logic signed [15:0]              out_read_coord_2,
  output logic signed [15:0]              out_read_coord_3
);
  import ngt_pkg::*;
  localparam int N = NUM_CENTROIDS;

  state_t st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r;
  opcode_t op_r;
  logic [3:0] ep_r, slot_r;
  crd_t smp_r [MAXD];
  crd_t in_crd [MAXD];
  logic [SLOT_W-1:0] best_r;
  dist_t best_d_r;
  logic [3:0] o_slot_r;
  dist_t o_dist_r;
  crd_t o_crd_r [MAXD];
  logic ov_r;

  crd_t lcrd [N][MAXD];
  dist_t ldist [N];
  logic [SLOT_W-1:0] lrank [N];
  logic [15:0] lw [N];

  assign in_crd[0] = in_coord_0;
  assign in_crd[1] = in_coord_1;
  assign in_crd[2] = in_coord_2;
  assign in_crd[3] = in_coord_3;

  wire acc = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE) || ov_r;
  wire ep_ok = 32'(in_epoch) < NUM_EPOCHS;
  wire slot_ok = 32'(in_slot) < N;
  wire train_ep_ok = 32'(ep_r) < NUM_EPOCHS;
  wire [SLOT_W-1:0] pidx = cnt_r[SLOT_W-1:0];

  // weight memory per lane, addressed by epoch and rank
  logic [WT_AW-1:0] wr_addr;
  assign wr_addr = WT_AW'(32'(in_epoch[EP_W-1:0]) * N + 32'(in_slot[SLOT_W-1:0]));
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_lane
      logic [WT_AW-1:0] rd_addr;
      assign rd_addr = WT_AW'(32'(ep_r[EP_W-1:0]) * N + 32'(lrank[g]));
      ngt_ram #(.WIDTH(16), .DEPTH(WT_DEPTH)) u_wt (
        .clk(clk),
        .we(acc && in_opcode == OP_LOAD_WEIGHT && ep_ok && slot_ok),
        .waddr(wr_addr), .wdata(in_weight), .raddr(rd_addr), .rdata(lw[g])
      );
      ngt_lane u_lane (
        .clk(clk),
        .ld_en(acc && in_opcode == OP_WRITE && slot_ok &&
               in_slot[SLOT_W-1:0] == SLOT_W'(g)),
        .ld_crd(in_crd),
        .dist_en(st_r == ST_DIST && cnt_r == '0),
        .smp(smp_r),
        .rank_clr(st_r == ST_DIST),
        .rank_en(st_r == ST_RANK),
        .peer_dist(ldist[pidx]),
        .peer_lower(pidx < SLOT_W'(g)),
        .upd_en(st_r == ST_UPD && cnt_r == CNT_W'(1) && train_ep_ok),
        .upd_w(lw[g]),
        .crd(lcrd[g]), .sqd(ldist[g]), .rank(lrank[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (acc) st_nxt = (opcode_t'(in_opcode) == OP_TRAIN) ? ST_DIST : ST_OUT;
      ST_DIST: if (cnt_r == CNT_W'(1)) st_nxt = ST_RANK;
      ST_RANK: if (cnt_r == CNT_W'(N - 1)) st_nxt = ST_UPD;
      ST_UPD:  if (cnt_r == CNT_W'(1)) st_nxt = ST_OUT;
      ST_OUT:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (st_r != st_nxt) cnt_r <= '0;
      else cnt_r <= cnt_r + 1'b1;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (st_r == ST_OUT) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r <= opcode_t'(in_opcode);
      ep_r <= in_epoch;
      slot_r <= in_slot;
      smp_r <= in_crd;
    end
    // winner search rides on the rank sweep; strict compare keeps the lower slot
    if (st_r == ST_RANK) begin
      if (cnt_r == '0 || ldist[pidx] < best_d_r) begin
        best_r <= pidx;
        best_d_r <= ldist[pidx];
      end
    end
    if (st_r == ST_OUT) begin
      o_slot_r <= '0;
      o_dist_r <= '0;
      for (int k = 0; k < MAXD; k++) o_crd_r[k] <= '0;
      if (op_r == OP_TRAIN) begin
        o_slot_r <= 4'(best_r);
        o_dist_r <= best_d_r;
      end else if (op_r == OP_READ && 32'(slot_r) < N) begin
        for (int k = 0; k < DIMS; k++) o_crd_r[k] <= lcrd[slot_r[SLOT_W-1:0]][k];
      end
    end
  end

  assign out_valid = ov_r;
  assign out_winner_slot = o_slot_r;
  assign out_winner_sq_distance = o_dist_r;
  assign out_read_coord_0 = o_crd_r[0];
  assign out_read_coord_1 = o_crd_r[1];
  assign out_read_coord_2 = o_crd_r[2];
  assign out_read_coord_3 = o_crd_r[3];
endmodule
`default_nettype wire

[src/ngt_checker.sv]
// Port-level checker for the neural gas trainer, bound to the top level.
`default_nettype none
module ngt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [34:0] out_winner_sq_distance,
  input wire logic signed [15:0] out_read_coord_0
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_winner_sq_distance))
    else $error("result dropped while stalled");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while result pending");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken without gap");
  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_winner_sq_distance != '0 |-> out_read_coord_0 == '0)
    else $error("train result carries read data");
endmodule

bind neural_gas_trainer_top ngt_checker u_ngt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_winner_sq_distance(out_winner_sq_distance),
  .out_read_coord_0(out_read_coord_0)
);
`default_nettype wire

[test/neural_gas_trainer_top_tb.sv]
// Self-checking testbench for the neural gas trainer: directed table, random traffic, stalls.
`default_nettype none
module neural_gas_trainer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ngt_pkg::*;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] epoch;
    logic [3:0] slot;
    logic [15:0] weight;
    logic [15:0] c0, c1, c2, c3;
  } request_t;

  typedef struct packed {
    logic [3:0] win;
    logic [34:0] sqd;
    logic [15:0] r0, r1, r2, r3;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [3:0] in_epoch = '0;
  logic [3:0] in_slot = '0;
  logic [15:0] in_weight = '0;
  logic signed [15:0] in_coord_0 = '0, in_coord_1 = '0, in_coord_2 = '0, in_coord_3 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_winner_slot;
  logic [34:0] out_winner_sq_distance;
  logic signed [15:0] out_read_coord_0, out_read_coord_1, out_read_coord_2, out_read_coord_3;

  neural_gas_trainer_top u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of block state
  logic signed [15:0] centroid_sh [NUM_CENTROIDS][MAXD];
  logic [15:0] weight_sh [NUM_EPOCHS][NUM_CENTROIDS];
  answer_t answers_due [$];
  int errors = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;

  function automatic logic signed [15:0] coord_of(request_t r, int k);
    case (k)
      0: return r.c0;
      1: return r.c1;
      2: return r.c2;
      default: return r.c3;
    endcase
  endfunction

  function automatic logic signed [15:0] nudge(logic signed [15:0] s, logic signed [15:0] c,
                                                logic [15:0] w);
    longint prod, delta, sum;
    prod = longint'(w) * (longint'(s) - longint'(c)) + 32768;
    delta = prod >>> 16;
    sum = longint'(c) + delta;
    if (sum > 32767) return 16'sh7fff;
    if (sum < -32768) return 16'sh8000;
    return sum[15:0];
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    logic [34:0] dscr [NUM_CENTROIDS];
    longint acc, df;
    int best, rank;
    a = '0;
    case (opcode_t'(r.opcode))
      OP_TRAIN: begin
        best = 0;
        for (int d = 0; d < NUM_CENTROIDS; d++) begin
          acc = 0;
          for (int k = 0; k < DIMS; k++) begin
            df = longint'(coord_of(r, k)) - longint'(centroid_sh[d][k]);
            acc += df * df;
          end
          dscr[d] = acc[34:0];
          if (dscr[d] < dscr[best]) best = d;
        end
        a.win = best[3:0];
        a.sqd = dscr[best];
        if (r.epoch < NUM_EPOCHS) begin
          for (int d = 0; d < NUM_CENTROIDS; d++) begin
            rank = 0;
            for (int e = 0; e < NUM_CENTROIDS; e++)
              if (dscr[e] < dscr[d] || (dscr[e] == dscr[d] && e < d)) rank++;
            for (int k = 0; k < DIMS; k++)
              centroid_sh[d][k] = nudge(coord_of(r, k), centroid_sh[d][k],
                                        weight_sh[r.epoch][rank]);
          end
        end
      end
      OP_LOAD_WEIGHT: begin
        if (r.epoch < NUM_EPOCHS) weight_sh[r.epoch][r.slot] = r.weight;
      end
      OP_READ: begin
        a.r0 = centroid_sh[r.slot][0];
        if (DIMS > 1) a.r1 = centroid_sh[r.slot][1];
        if (DIMS > 2) a.r2 = centroid_sh[r.slot][2];
        if (DIMS > 3) a.r3 = centroid_sh[r.slot][3];
      end
      default: begin
        for (int k = 0; k < DIMS; k++) centroid_sh[r.slot][k] = coord_of(r, k);
      end
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Valid stays up after an accept; drop it only when a gap follows
  task automatic send_request(request_t r, bit has_want, answer_t want);
    answer_t a;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= r.opcode;
    in_epoch <= r.epoch;
    in_slot <= r.slot;
    in_weight <= r.weight;
    in_coord_0 <= r.c0;
    in_coord_1 <= r.c1;
    in_coord_2 <= r.c2;
    in_coord_3 <= r.c3;
    do @(posedge clk); while (in_stall);
    a = predict_answer(r);
    if (has_want && a != want) report_mismatch("directed row", a[63:0], want[63:0]);
    answers_due.push_back(a);
  endtask

  function automatic request_t rand_coords(request_t r, int span);
    r.c0 = (span == 0) ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
    r.c1 = (span == 0) ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
    r.c2 = 16'($urandom);
    r.c3 = 16'($urandom);
    return r;
  endfunction

  // Receiver side: random stalls, one long hold on request
  always @(posedge clk) begin
    int g;
    if (long_hold) begin
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 70) begin
      out_stall <= 1'b0;
    end else begin
      g = $urandom_range(0, 99);
      out_stall <= (g < 90) ? 1'b1 : ($urandom_range(0, 1) == 1);
    end
  end

  // Check results
  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_winner_slot, out_winner_sq_distance, out_read_coord_0, out_read_coord_1,
             out_read_coord_2, out_read_coord_3};
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected result", got[63:0], 64'd0);
      end else begin
        want = answers_due.pop_front();
        if (got.win != want.win) report_mismatch("winner_slot", got.win, want.win);
        if (got.sqd != want.sqd) report_mismatch("winner_sq_distance", got.sqd, want.sqd);
        if (got.r0 != want.r0) report_mismatch("read_coord_0", got.r0, want.r0);
        if (got.r1 != want.r1) report_mismatch("read_coord_1", got.r1, want.r1);
        if (got.r2 != want.r2) report_mismatch("read_coord_2", got.r2, want.r2);
        if (got.r3 != want.r3) report_mismatch("read_coord_3", got.r3, want.r3);
      end
    end
  end

  // Watchdog: cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("neural_gas_trainer_top_tb NOT OK");
      $finish;
    end
  end

  // Directed rows: opcode epoch slot weight c0 c1 c2 c3, want valid, want
  typedef struct {
    request_t r;
    bit has_want;
    answer_t want;
  } row_t;

  initial begin
    row_t rows [$];
    request_t r;
    answer_t none;
    int pick, hold;
    none = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill all weights and centroids first so nothing undefined is ever read
    for (int e = 0; e < NUM_EPOCHS; e++)
      for (int s = 0; s < NUM_CENTROIDS; s++)
        rows.push_back('{'{OP_LOAD_WEIGHT, e[3:0], s[3:0], (e == 0) ? 16'hffff :
                          (e == 1) ? 16'h0000 : 16'($urandom), '0, '0, '0, '0}, 1'b1, none});
    for (int s = 0; s < NUM_CENTROIDS; s++)
      rows.push_back('{'{OP_WRITE, 4'd0, s[3:0], 16'd0, 16'(s * 256), 16'(-s * 128),
                        16'h1234, 16'hfedc}, 1'b1, none});
    // Extremes, out of range cases, ties
    rows.push_back('{'{OP_WRITE, 4'd0, 4'd0, 16'd0, 16'sh7fff, 16'sh8000, 16'hffff, 16'h0},
                     1'b1, none});
    rows.push_back('{'{OP_READ, 4'd0, 4'd0, 16'd0, '0, '0, '0, '0}, 1'b1,
                     '{4'd0, 35'd0, 16'sh7fff, (DIMS > 1) ? 16'sh8000 : 16'h0, 16'h0, 16'h0}});
    rows.push_back('{'{OP_TRAIN, 4'd15, 4'd9, 16'hffff, 16'sh8000, 16'sh7fff, '0, '0},
                     1'b0, none});
    rows.push_back('{'{OP_LOAD_WEIGHT, 4'd12, 4'd3, 16'h5555, '0, '0, '0, '0}, 1'b1, none});
    rows.push_back('{'{OP_TRAIN, 4'd1, 4'd0, 16'd0, 16'sh0100, 16'sh0080, '0, '0}, 1'b0, none});
    rows.push_back('{'{OP_TRAIN, 4'd0, 4'd0, 16'd0, 16'sh7fff, 16'sh7fff, '1, '1}, 1'b0, none});
    rows.push_back('{'{OP_TRAIN, 4'd9, 4'd0, 16'd0, 16'sh8000, 16'sh8000, '0, '0}, 1'b0, none});
    rows.push_back('{'{OP_WRITE, 4'd0, 4'd5, 16'd0, '0, '0, '0, '0}, 1'b1, none});
    rows.push_back('{'{OP_WRITE, 4'd0, 4'd6, 16'd0, '0, '0, '0, '0}, 1'b1, none});
    rows.push_back('{'{OP_TRAIN, 4'd1, 4'd0, 16'd0, '0, '0, '0, '0}, 1'b0, none});
    rows.push_back('{'{OP_READ, 4'd0, 4'd15, 16'd0, '0, '0, '0, '0}, 1'b0, none});
    foreach (rows[i]) send_request(rows[i].r, rows[i].has_want, rows[i].want);

    for (int n = 0; n < 1700; n++) begin
      if (n == 400) begin
        // Hold the receiver off while the sender keeps offering requests
        fork
          begin
            long_hold = 1'b1;
            hold = 0;
            while (hold < 300) begin
              @(posedge clk);
              hold++;
            end
            long_hold = 1'b0;
          end
        join_none
      end
      if (n == 900) begin
        // Pause the sender until every result is back
        in_valid <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0) @(posedge clk);
      end
      r = '0;
      pick = $urandom_range(0, 99);
      r.epoch = (pick < 95) ? 4'($urandom_range(0, NUM_EPOCHS - 1)) : 4'($urandom);
      r.slot = 4'($urandom);
      r.weight = 16'($urandom);
      r = rand_coords(r, ($urandom_range(0, 3) == 0) ? 0 : 2048);
      pick = $urandom_range(0, 99);
      if (pick < 55) r.opcode = OP_TRAIN;
      else if (pick < 70) r.opcode = OP_LOAD_WEIGHT;
      else if (pick < 88) r.opcode = OP_READ;
      else r.opcode = OP_WRITE;
      send_request(r, 1'b0, none);
    end

    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("neural_gas_trainer_top_tb OK");
    end else begin
      $display("neural_gas_trainer_top_tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
src/ngt_pkg.sv
src/ngt_ram.sv
src/ngt_lane.sv
src/neural_gas_trainer_top.sv
src/ngt_checker.sv
test/neural_gas_trainer_top_tb.sv
